// ===== sv/nap_pkg.sv =====
// Shared types and constants for the nearest-above partner pairing block.
`timescale 1ns / 1ps
`default_nettype none
package nap_pkg;

    localparam int MAX_EDGES = 64;
    localparam int SLOT_W    = 6;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_AXIS  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OUT_LOADED = 3'd0,
        OUT_PAIRED = 3'd1,
        OUT_WAIT   = 3'd2,
        OUT_WALL   = 3'd3,
        OUT_AXIS   = 3'd4,
        OUT_NOAXIS = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       y_value;
        logic signed [31:0] angle_key;
        logic [15:0]       chain_id;
        logic              entry_valid;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [SLOT_W-1:0] found_slot;
        logic [15:0]       found_chain;
        logic [31:0]       gap;
    } out_beat_t;

    // Running record that walks the cell row; an axis sweep reuses the
    // best fields for the lowest entry and near_claimed for its claim bit.
    typedef struct packed {
        logic              valid;
        logic              axis;
        logic [31:0]       qy;
        logic              any;
        logic [31:0]       near_dy;
        logic              near_claimed;
        logic              have_best;
        logic [31:0]       best_dy;
        logic signed [31:0] best_key;
        logic [SLOT_W-1:0] best_slot;
        logic [15:0]       best_chain;
    } sweep_t;

    typedef struct packed {
        logic              load_en;
        logic [SLOT_W-1:0] load_slot;
        logic [31:0]       load_y;
        logic signed [31:0] load_key;
        logic [15:0]       load_chain;
        logic              load_active;
        logic              claim_en;
        logic [SLOT_W-1:0] claim_slot;
        logic              clear_claims;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/nap_cell.sv =====
// One table entry of the pairing row with its stage of the sweep record.
`timescale 1ns / 1ps
`default_nettype none
module nap_cell
    import nap_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] idx,
    input  wire cell_ctrl_t        ctrl,
    input  wire sweep_t            rec_in,
    output sweep_t                 rec_out
);

    logic [31:0]        y_reg;
    logic signed [31:0] key_reg;
    logic [15:0]        chain_reg;
    logic               active_reg;
    logic               claimed_reg;
    sweep_t             rec_reg;
    sweep_t             rec_next;
    logic [31:0]        dy;
    logic               above;

    always_comb
    begin
        rec_next = rec_in;
        dy       = y_reg - rec_in.qy;
        above    = active_reg && (y_reg > rec_in.qy);
        if (rec_in.valid)
        begin
            if (rec_in.axis)
            begin
                if (active_reg && (!rec_in.have_best || (y_reg < rec_in.best_dy)))
                begin
                    rec_next.have_best    = 1'b1;
                    rec_next.best_dy      = y_reg;
                    rec_next.best_slot    = idx;
                    rec_next.best_chain   = chain_reg;
                    rec_next.near_claimed = claimed_reg;
                end
            end
            else if (above)
            begin
                if (!rec_in.any || (dy < rec_in.near_dy))
                begin
                    rec_next.near_dy      = dy;
                    rec_next.near_claimed = claimed_reg;
                end
                rec_next.any = 1'b1;
                if (!claimed_reg && (!rec_in.have_best || (dy < rec_in.best_dy) ||
                    ((dy == rec_in.best_dy) && (key_reg < $signed(rec_in.best_key)))))
                begin
                    rec_next.have_best  = 1'b1;
                    rec_next.best_dy    = dy;
                    rec_next.best_key   = key_reg;
                    rec_next.best_slot  = idx;
                    rec_next.best_chain = chain_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg     <= '0;
            active_reg  <= 1'b0;
            claimed_reg <= 1'b0;
        end
        else
        begin
            rec_reg <= rec_next;
            if (ctrl.load_en && (ctrl.load_slot == idx))
            begin
                active_reg <= ctrl.load_active;
            end
            if (ctrl.clear_claims || (ctrl.load_en && (ctrl.load_slot == idx)))
            begin
                claimed_reg <= 1'b0;
            end
            else if (ctrl.claim_en && (ctrl.claim_slot == idx))
            begin
                claimed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en && (ctrl.load_slot == idx))
        begin
            y_reg     <= ctrl.load_y;
            key_reg   <= ctrl.load_key;
            chain_reg <= ctrl.load_chain;
        end
    end

    assign rec_out = rec_reg;

endmodule
`default_nettype wire

// ===== sv/nearest_above_partner_pairing_top.sv =====
// Top level: controller and the row of pairing cells.
// Usage:
//   Input channel in_valid / in_stall / in_beat carries one item per beat:
//   load (mode 0), pairing query (mode 1) or end of pass (mode 2).
//   Output channel out_valid / out_stall / out_beat carries one result per
//   item; mode 3 items are taken and give no result.
//   A load answers on the cycle after it is taken; one per cycle if unstalled.
//   A query or end of pass walks a record through the row of 64 cells, one
//   cell per cycle, into a finish register, then commits its result to the
//   output register once that is free; the next item is taken once that
//   result has been placed in the output register.
//   One item is in the block at a time; in_stall is high while it works.
//   The result register holds its beat while out_stall is high; a finished
//   sweep waits in the controller until that register frees up, and the
//   claim update is made at that point.
//   Reset clears all active and claim bits, the controller and the output
//   valid; entry payload is unknown until loaded.
`timescale 1ns / 1ps
`default_nettype none
module nearest_above_partner_pairing_top
    import nap_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_beat,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_beat
);

    state_t     state_reg;
    state_t     state_next;
    sweep_t     fin_reg;
    sweep_t     fin_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_beat_t  out_beat_reg;
    out_beat_t  out_beat_next;
    cell_ctrl_t ctrl;
    sweep_t     head;
    sweep_t     link [MAX_EDGES+1];
    logic       accept;
    logic       out_free;
    logic       commit;

    assign link[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EDGES; gi++)
        begin : g_cell
            nap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (SLOT_W'(gi)),
                .ctrl    (ctrl),
                .rec_in  (link[gi]),
                .rec_out (link[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        in_stall       = (state_reg != ST_IDLE) || !out_free;
        accept         = in_valid && !in_stall;
        commit         = (state_reg == ST_FINISH) && out_free;
        state_next     = state_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_beat_next  = out_beat_reg;
        head           = '0;
        ctrl           = '0;

        ctrl.load_slot   = in_beat.slot;
        ctrl.load_y      = in_beat.y_value;
        ctrl.load_key    = in_beat.angle_key;
        ctrl.load_chain  = in_beat.chain_id;
        ctrl.load_active = in_beat.entry_valid;
        ctrl.claim_slot  = fin_reg.best_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_beat.mode == MODE_LOAD)
                    begin
                        ctrl.load_en   = 1'b1;
                        out_valid_next = 1'b1;
                        out_beat_next  = '0;
                        out_beat_next.outcome = OUT_LOADED;
                    end
                    else if ((in_beat.mode == MODE_QUERY) || (in_beat.mode == MODE_AXIS))
                    begin
                        head.valid = 1'b1;
                        head.axis  = (in_beat.mode == MODE_AXIS);
                        head.qy    = in_beat.y_value;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (link[MAX_EDGES].valid)
                begin
                    fin_next   = link[MAX_EDGES];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next  = '0;
                    state_next     = ST_IDLE;
                    if (fin_reg.axis)
                    begin
                        ctrl.clear_claims = 1'b1;
                        if (fin_reg.have_best && !fin_reg.near_claimed)
                        begin
                            out_beat_next.outcome     = OUT_AXIS;
                            out_beat_next.found_slot  = fin_reg.best_slot;
                            out_beat_next.found_chain = fin_reg.best_chain;
                        end
                        else
                        begin
                            out_beat_next.outcome = OUT_NOAXIS;
                        end
                    end
                    else if (!fin_reg.any)
                    begin
                        out_beat_next.outcome = OUT_WALL;
                    end
                    else if (fin_reg.near_claimed || !fin_reg.have_best)
                    begin
                        out_beat_next.outcome = OUT_WAIT;
                    end
                    else
                    begin
                        ctrl.claim_en             = 1'b1;
                        out_beat_next.outcome     = OUT_PAIRED;
                        out_beat_next.found_slot  = fin_reg.best_slot;
                        out_beat_next.found_chain = fin_reg.best_chain;
                        out_beat_next.gap         = fin_reg.best_dy;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg      <= fin_next;
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        link[MAX_EDGES].valid |-> (state_reg == ST_SCAN))
        else $error("sweep record left the row outside a scan");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("commit did not post a result");

    a_claim_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.claim_en |-> (fin_reg.have_best && !fin_reg.axis))
        else $error("claim issued without a paired entry");

endmodule
`default_nettype wire
